@@ src/ede_pkg.sv @@
// Package for the edit distance engine: operation codes, widths, the token
// that travels along the cell chain. No dependencies.
package ede_pkg;

    localparam int DIST_W          = 16;
    localparam int SYM_W           = 8;
    localparam int OP_W            = 2;
    localparam int MAX_REF_DEFAULT = 64;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // One wavefront slot moving down the chain.
    // Query: left = new value of the previous row entry, diag = its old value.
    // Report: left = distance carried so far, ovf = sticky overflow so far.
    typedef struct packed {
        logic              valid;
        logic              rpt;
        logic [SYM_W-1:0]  sym;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] diag;
        logic              ovf;
    } ede_token_t;

endpackage

@@ src/ede_cmd_if.sv @@
// Request channel of the edit distance engine: valid/ready plus op and symbol.
// Depends on ede_pkg.
interface ede_cmd_if import ede_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface

@@ src/ede_result_if.sv @@
// Result channel of the edit distance engine: valid/ready plus distance and
// overflow. Depends on ede_pkg.
interface ede_result_if import ede_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

@@ src/ede_cell.sv @@
// One systolic cell: holds one reference byte and one entry of the distance
// row, updates it from the token of its left neighbor. Depends on ede_pkg.
module ede_cell import ede_pkg::*; #(
    parameter int INDEX = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [SYM_W-1:0] wr_sym,
    input  ede_token_t       tok_in,
    output ede_token_t       tok_out
);

    logic [SYM_W-1:0]  ch_reg, ch_next;
    logic              act_reg, act_next;
    logic [DIST_W-1:0] d_reg, d_next;
    logic              ovf_reg, ovf_next;
    ede_token_t        tok_reg, tok_next;

    logic [DIST_W:0]   up, left, sub, best;
    logic [DIST_W-1:0] best_sat;
    logic              sat;

    always_comb
    begin
        up   = {1'b0, d_reg} + 1'b1;
        left = {1'b0, tok_in.left} + 1'b1;
        sub  = {1'b0, tok_in.diag} + {{DIST_W{1'b0}}, (ch_reg != tok_in.sym)};
        best = up;
        if (left < best)
        begin
            best = left;
        end
        if (sub < best)
        begin
            best = sub;
        end
        sat      = best[DIST_W];
        best_sat = sat ? DIST_MAX : best[DIST_W-1:0];
    end

    always_comb
    begin
        ch_next  = ch_reg;
        act_next = act_reg;
        d_next   = d_reg;
        ovf_next = ovf_reg;
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.rpt && act_reg)
        begin
            d_next        = best_sat;
            ovf_next      = ovf_reg | sat;
            tok_next.left = best_sat;
            tok_next.diag = d_reg;
        end
        if (tok_in.valid && tok_in.rpt)
        begin
            // pick up this entry if it is the last live one, then clear
            if (act_reg)
            begin
                tok_next.left = d_reg;
            end
            tok_next.ovf = tok_in.ovf | ovf_reg;
            d_next       = DIST_W'(INDEX);
            act_next     = 1'b0;
            ovf_next     = 1'b0;
        end
        if (wr_en)
        begin
            ch_next  = wr_sym;
            act_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            d_reg   <= DIST_W'(INDEX);
            ovf_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            d_reg   <= d_next;
            ovf_reg <= ovf_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ src/edit_distance_engine_unit.sv @@
// Top level of the Levenshtein edit distance engine: head stage, a chain of
// MAX_REF ede_cell instances and a two-entry result buffer.
// Depends on ede_pkg, ede_cmd_if, ede_result_if and ede_cell.
//
//   channel  modport  handshake      payload
//   cmd      sink     valid / ready  op[1:0], symbol[7:0]
//   result   source   valid / ready  distance[15:0], overflow
//
// Append and query requests are taken one per cycle while cmd.ready is high;
//   a query moves one cell per cycle down the chain.
// A report travels behind all earlier queries; its result passes the head and
//   each cell register into the result register. Hold cmd.ready low until it
//   has left the chain and while the second result slot is occupied.
// Reset: asynchronous, active low; clears the row to 0..MAX_REF, the lengths
//   and the overflow flags at once, no sweep.
// Stalls on result never stall the chain; the spare slot absorbs one report.
module edit_distance_engine_unit import ede_pkg::*; #(
    parameter int MAX_REF = MAX_REF_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ede_cmd_if.sink      cmd,
    ede_result_if.source result
);

    localparam int RL_W = $clog2(MAX_REF + 1);

    // head state: row entry zero is the query count
    logic [DIST_W-1:0] ql_reg, ql_next;
    logic [RL_W-1:0]   rl_reg, rl_next;
    logic              flag_reg, flag_next;
    logic              busy_reg, busy_next;
    ede_token_t        tok [0:MAX_REF];
    ede_token_t        head_reg, head_next;

    logic              accept;
    logic              app_en;
    logic [MAX_REF-1:0] wr_en;
    ede_token_t        tail;

    // result buffer
    logic              out_v_reg, hold_v_reg;
    logic [DIST_W-1:0] out_d_reg, hold_d_reg;
    logic              out_o_reg, hold_o_reg;
    logic              pop, done;

    assign cmd.ready = !busy_reg && !hold_v_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign app_en    = accept && (cmd.op == OP_APPEND) && (ql_reg == '0)
                       && (rl_reg < RL_W'(MAX_REF));

    always_comb
    begin
        ql_next   = ql_reg;
        rl_next   = rl_reg;
        flag_next = flag_reg;
        busy_next = busy_reg;
        head_next = '0;
        if (accept)
        begin
            case (cmd.op)
                OP_APPEND:
                begin
                    // drop once the query has started; flag a full reference
                    if (ql_reg == '0)
                    begin
                        if (rl_reg < RL_W'(MAX_REF))
                        begin
                            rl_next = rl_reg + 1'b1;
                        end
                        else
                        begin
                            flag_next = 1'b1;
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (ql_reg == DIST_MAX)
                    begin
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        ql_next = ql_reg + 1'b1;
                    end
                    head_next.valid = 1'b1;
                    head_next.sym   = cmd.symbol;
                    head_next.left  = ql_next;
                    head_next.diag  = ql_reg;
                end
                OP_REPORT:
                begin
                    head_next.valid = 1'b1;
                    head_next.rpt   = 1'b1;
                    head_next.left  = ql_reg;
                    head_next.ovf   = flag_reg;
                    ql_next   = '0;
                    rl_next   = '0;
                    flag_next = 1'b0;
                    busy_next = 1'b1;
                end
                default:
                begin
                    // unused op: ignore
                end
            endcase
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ql_reg   <= '0;
            rl_reg   <= '0;
            flag_reg <= 1'b0;
            busy_reg <= 1'b0;
            head_reg <= '0;
        end
        else
        begin
            ql_reg   <= ql_next;
            rl_reg   <= rl_next;
            flag_reg <= flag_next;
            busy_reg <= busy_next;
            head_reg <= head_next;
        end
    end

    assign tok[0] = head_reg;

    // cell j holds reference byte j-1 and row entry j
    for (genvar j = 1; j <= MAX_REF; j++)
    begin : g_cell
        assign wr_en[j-1] = app_en && (rl_reg == RL_W'(j - 1));

        ede_cell #(
            .INDEX (j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en[j-1]),
            .wr_sym  (cmd.symbol),
            .tok_in  (tok[j-1]),
            .tok_out (tok[j])
        );
    end

    assign tail = tok[MAX_REF];
    assign done = tail.valid && tail.rpt;
    assign pop  = out_v_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                // land in the output register if it frees, else park it
                if (!out_v_reg || pop)
                begin
                    out_v_reg <= 1'b1;
                end
                else
                begin
                    hold_v_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_v_reg  <= hold_v_reg;
                hold_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            if (!out_v_reg || pop)
            begin
                out_d_reg <= tail.left;
                out_o_reg <= tail.ovf;
            end
            else
            begin
                hold_d_reg <= tail.left;
                hold_o_reg <= tail.ovf;
            end
        end
        else if (pop && hold_v_reg)
        begin
            out_d_reg <= hold_d_reg;
            out_o_reg <= hold_o_reg;
        end
    end

    assign result.valid    = out_v_reg;
    assign result.distance = out_d_reg;
    assign result.overflow = out_o_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for edit_distance_engine_unit: directed table, then
// random reference/query pairs under several idle mixes.
// Depends on ede_pkg, ede_cmd_if, ede_result_if and the engine RTL.
module tb_top;
    import ede_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REF = MAX_REF_DEFAULT;

    // Op code 3 is not decoded by the engine; it must leave no trace.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles to let the chain empty.
    localparam int DRAIN_CYCLES = MAX_REF + 8;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } dist_report_t;

    localparam dist_report_t NO_RPT = '0;

    // One row of the directed table. known = 1 means the report value is
    // given here; otherwise the predictor supplies it.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic             known;
        dist_report_t     rpt;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] send_idle;
        logic [7:0] recv_stall;
    } idle_mix_t;

    logic clk = 1'b0;
    logic rst_n;

    ede_cmd_if    cmd_if ();
    ede_result_if result_if ();

    edit_distance_engine_unit #(
        .MAX_REF (MAX_REF)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (result_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: stored reference, current DP row, lengths and the
    // sticky overflow bit; the row and the query count at the engine's widths.
    // ------------------------------------------------------------------
    logic [SYM_W-1:0]  ref_bytes [MAX_REF];
    logic [DIST_W-1:0] dp_row [MAX_REF+1];
    int                ref_count;
    logic [DIST_W-1:0] query_count;
    logic              sticky_ovf;

    // Distance reports still owed by the engine, oldest first.
    dist_report_t pending_reports [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int pair_no        = 0;
    int n_fail         = 0;

    // Directed table: reset state, empty reference, match and mismatch,
    // append after query start, the unused op, symbol extremes.
    stim_row_t directed_rows [17] = '{
        '{OP_REPORT, 8'h00, 1'b1, '{16'd0, 1'b0}},   // right after reset
        '{OP_QUERY,  8'h00, 1'b0, NO_RPT},           // empty reference
        '{OP_QUERY,  8'hFF, 1'b0, NO_RPT},
        '{OP_REPORT, 8'h00, 1'b1, '{16'd2, 1'b0}},   // two insertions
        '{OP_APPEND, 8'hFF, 1'b0, NO_RPT},
        '{OP_APPEND, 8'h00, 1'b0, NO_RPT},
        '{OP_APPEND, 8'hA5, 1'b0, NO_RPT},
        '{OP_QUERY,  8'hFF, 1'b0, NO_RPT},
        '{OP_QUERY,  8'h5A, 1'b0, NO_RPT},
        '{OP_QUERY,  8'hA5, 1'b0, NO_RPT},
        '{OP_APPEND, 8'h11, 1'b0, NO_RPT},           // too late, must be dropped
        '{OP_REPORT, 8'hFF, 1'b0, NO_RPT},
        '{OP_UNUSED, 8'hFF, 1'b0, NO_RPT},           // no effect at all
        '{OP_REPORT, 8'h00, 1'b1, '{16'd0, 1'b0}},
        '{OP_APPEND, 8'h41, 1'b0, NO_RPT},
        '{OP_QUERY,  8'h41, 1'b0, NO_RPT},
        '{OP_REPORT, 8'h00, 1'b1, '{16'd0, 1'b0}}    // exact match
    };

    // Idle mixes for the random part: none, sender, receiver, both.
    idle_mix_t idle_mixes [4] = '{
        '{8'd0,  8'd0},
        '{8'd54, 8'd0},
        '{8'd0,  8'd54},
        '{8'd13, 8'd13}
    };

    // Put the predictor back to its cleared state (reset and after a report).
    function automatic void clear_pair();
        for (int j = 0; j <= MAX_REF; j++)
            dp_row[j] = DIST_W'(j);
        ref_count   = 0;
        query_count = '0;
        sticky_ovf  = 1'b0;
    endfunction

    // Apply one accepted request to the predictor; return 1 with the report
    // value when the request produces a result.
    function automatic bit advance_edit_row(input logic [OP_W-1:0] op,
                                            input logic [SYM_W-1:0] sym,
                                            output dist_report_t rpt);
        logic [DIST_W-1:0] diag;
        logic [DIST_W:0]   up;
        logic [DIST_W:0]   left;
        logic [DIST_W:0]   sub;
        logic [DIST_W:0]   best;
        rpt = NO_RPT;
        case (op)
            OP_APPEND:
            begin
                // Appends only count before the first query of a pair.
                if (query_count == '0)
                begin
                    if (ref_count >= MAX_REF)
                        sticky_ovf = 1'b1;
                    else
                    begin
                        ref_bytes[ref_count] = sym;
                        ref_count++;
                    end
                end
                return 1'b0;
            end
            OP_QUERY:
            begin
                if (query_count == DIST_MAX)
                    sticky_ovf = 1'b1;
                else
                    query_count++;
                diag      = dp_row[0];
                dp_row[0] = query_count;
                for (int j = 1; j <= ref_count; j++)
                begin
                    up   = {1'b0, dp_row[j]} + 1'b1;
                    left = {1'b0, dp_row[j-1]} + 1'b1;
                    sub  = {1'b0, diag} + ((ref_bytes[j-1] == sym) ? 1'b0 : 1'b1);
                    best = up;
                    if (left < best)
                        best = left;
                    if (sub < best)
                        best = sub;
                    diag = dp_row[j];
                    if (best > {1'b0, DIST_MAX})
                    begin
                        sticky_ovf = 1'b1;
                        dp_row[j]  = DIST_MAX;
                    end
                    else
                        dp_row[j] = best[DIST_W-1:0];
                end
                return 1'b0;
            end
            OP_REPORT:
            begin
                rpt.distance = dp_row[ref_count];
                rpt.overflow = sticky_ovf;
                clear_pair();
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Present one request, idling first at the sender's rate, and hold it
    // until the engine takes it. Record the owed report on acceptance.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [SYM_W-1:0] sym,
                                input logic known,
                                input dist_report_t known_rpt);
        dist_report_t rpt;
        bit           has_rpt;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.op     <= op;
        cmd_if.symbol <= sym;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        has_rpt = advance_edit_row(op, sym, rpt);
        if (has_rpt)
            pending_reports.push_back(known ? known_rpt : rpt);
        items_sent++;
    endtask

    // Drop valid and hold off until every owed report is in and the chain
    // has had time to empty.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Narrow alphabets give plenty of matches; wide ones plenty of edits.
    function automatic logic [SYM_W-1:0] pick_symbol(input bit narrow,
                                                     input logic [SYM_W-1:0] base);
        if (narrow)
            return base + SYM_W'($urandom_range(0, 3));
        return SYM_W'($urandom_range(0, 255));
    endfunction

    // Stream random pairs: a reference, a query, a report. Mix in stray
    // requests of any op and late appends that the engine must ignore.
    task automatic stream_random_pairs(input int n_items);
        int               first;
        int               rlen;
        int               qlen;
        bit               narrow;
        logic [SYM_W-1:0] base;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_request(OP_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)),
                             1'b0, NO_RPT);
                continue;
            end
            pair_no++;
            // Every eighth pair brings the reference near, to or past its capacity.
            if (pair_no % 8 == 0)
                rlen = $urandom_range(MAX_REF - 2, MAX_REF + 6);
            else
                rlen = $urandom_range(0, 10);
            if ($urandom_range(0, 9) == 0)
                qlen = $urandom_range(0, 40);
            else
                qlen = $urandom_range(0, 12);
            narrow = ($urandom_range(0, 3) != 0);
            base   = SYM_W'($urandom_range(0, 255));
            repeat (rlen)
                send_request(OP_APPEND, pick_symbol(narrow, base), 1'b0, NO_RPT);
            for (int q = 0; q < qlen; q++)
            begin
                if (q > 0 && $urandom_range(0, 19) == 0)
                    send_request(OP_APPEND, pick_symbol(narrow, base), 1'b0, NO_RPT);
                send_request(OP_QUERY, pick_symbol(narrow, base), 1'b0, NO_RPT);
            end
            send_request(OP_REPORT, SYM_W'($urandom_range(0, 255)), 1'b0, NO_RPT);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted report against the oldest owed one,
    // then pick the next ready at the receiver's stall rate.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        dist_report_t want;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected report: distance %0d, overflow %0d",
                           result_if.distance, result_if.overflow);
                    n_fail++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (result_if.distance !== want.distance)
                    begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, result_if.distance);
                        n_fail++;
                    end
                    if (result_if.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, result_if.overflow);
                        n_fail++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cmd_if.valid  <= 1'b0;
        cmd_if.op     <= OP_APPEND;
        cmd_if.symbol <= '0;
        clear_pair();

        // Hold reset, then release it on a rising edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with no idling on either side.
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].sym,
                         directed_rows[i].known, directed_rows[i].rpt);
        wait_drained();

        // Random pairs, one quarter of the budget per idle mix. The drain
        // between mixes also pauses the sender until all reports are home.
        foreach (idle_mixes[m])
        begin
            send_idle_pct  = idle_mixes[m].send_idle;
            recv_stall_pct = idle_mixes[m].recv_stall;
            stream_random_pairs(350);
            wait_drained();
        end

        if (n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
